// File: rtl/gsa_pkg.sv
package gsa_pkg;

  // table geometry
  localparam int unsigned SlotCount = 1024;
  localparam int unsigned GenWidth  = 32;
  localparam int unsigned SlotW     = $clog2(SlotCount);
  localparam int unsigned CntW      = SlotW + 1;
  localparam int unsigned DataW     = 32;
  localparam int unsigned PaddrW    = 3;

  localparam logic [CntW-1:0]     IndexNone = CntW'(SlotCount);
  localparam logic [GenWidth-1:0] GenMax    = {GenWidth{1'b1}};
  localparam logic [GenWidth-1:0] GenFirst  = GenWidth'(1);

  // action codes
  localparam logic [1:0] ActCreate  = 2'd0;
  localparam logic [1:0] ActDestroy = 2'd1;
  localparam logic [1:0] ActCheck   = 2'd2;
  localparam logic [1:0] ActClear   = 2'd3;

  // status codes
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StStale = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  // register index of owner id
  localparam logic RegOwnerId = 1'b0;

  // shared unit operations
  localparam logic [1:0] AluEq  = 2'd0;
  localparam logic [1:0] AluLt  = 2'd1;
  localparam logic [1:0] AluInc = 2'd2;

  typedef struct packed {
    logic [1:0]       action;
    logic [DataW-1:0] handle_owner;
    logic [9:0]       handle_slot;
    logic [DataW-1:0] handle_generation;
  } gsa_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [DataW-1:0] out_owner;
    logic [9:0]       out_slot;
    logic [DataW-1:0] out_generation;
    logic [10:0]      live_count;
  } gsa_out_t;

  typedef struct packed {
    logic                alive;
    logic [GenWidth-1:0] gen;
    logic [CntW-1:0]     link;
  } slot_entry_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [DataW-1:0] res;
    logic             flag;
  } alu_rsp_t;

endpackage

// File: rtl/generational_slot_allocator.sv
// create steps through Own and Upd; destroy and check through Own, Range, Gen and Upd;
// clear through Upd alone; Upd waits while the output stalls; one item is taken at a time
// the steps are set by the single compare/increment unit doing one step a cycle
// and by the registered read of the slot memory
// reset clears the sequencer, free list head, high-water mark, live count and owner id (to 1)
// slot memory is not cleared; read data is used only for slots below the high-water mark
module generational_slot_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  gsa_pkg::gsa_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output gsa_pkg::gsa_out_t             out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gsa_pkg::PaddrW-1:0]    paddr,
  input  logic [gsa_pkg::DataW-1:0]     pwdata,
  output logic [gsa_pkg::DataW-1:0]     prdata,
  output logic                          pready
);
  import gsa_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StOwn   = 3'd1;
  localparam logic [2:0] StRange = 3'd2;
  localparam logic [2:0] StGen   = 3'd3;
  localparam logic [2:0] StUpd   = 3'd4;

  logic [2:0]       state_q, state_d;
  gsa_in_t          in_q;
  logic             flag_a_q, flag_a_d;
  logic             flag_b_q, flag_b_d;
  logic             flag_c_q, flag_c_d;
  logic [CntW-1:0]  free_head_q, free_head_d;
  logic [CntW-1:0]  used_q, used_d;
  logic [CntW-1:0]  live_q, live_d;
  logic [DataW-1:0] owner_q;
  logic             out_valid_q, out_valid_d;
  gsa_out_t         out_q, out_d;

  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;
  slot_entry_t      rd_entry;
  slot_entry_t      wr_entry;
  logic             ram_we;
  logic [SlotW-1:0] ram_waddr;
  logic             ram_re;
  logic [SlotW-1:0] ram_raddr;
  logic             in_xfer;
  logic             out_free;
  logic             is_create;
  logic             have_free;
  logic             handle_ok;
  logic             cfg_wr;

  assign in_stall_o  = (state_q != StIdle);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign is_create   = (in_q.action == ActCreate);
  assign have_free   = (free_head_q != IndexNone);
  assign handle_ok   = flag_a_q && flag_b_q && flag_c_q && rd_entry.alive;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegOwnerId);
  assign prdata = (paddr[2] == RegOwnerId) ? owner_q : '0;

  gsa_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  gsa_ram #(
    .Width ($bits(slot_entry_t)),
    .Depth (SlotCount)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_entry)
  );

  // slot read is issued in the Own state, the first work step of create, destroy and check
  assign ram_re    = (state_q == StOwn);
  assign ram_raddr = is_create ? free_head_q[SlotW-1:0] : in_q.handle_slot[SlotW-1:0];

  // operand selection for the shared unit
  always_comb begin
    alu_req = '0;
    case (state_q)
      StOwn: begin
        if (is_create) begin
          alu_req.op = AluLt;
          alu_req.a  = DataW'(used_q);
          alu_req.b  = DataW'(SlotCount);
        end else begin
          alu_req.op = AluEq;
          alu_req.a  = in_q.handle_owner;
          alu_req.b  = owner_q;
        end
      end
      StRange: begin
        alu_req.op = AluLt;
        alu_req.a  = DataW'(in_q.handle_slot);
        alu_req.b  = DataW'(used_q);
      end
      StGen: begin
        alu_req.op = AluEq;
        alu_req.a  = in_q.handle_generation;
        alu_req.b  = DataW'(rd_entry.gen);
      end
      StUpd: begin
        alu_req.op = AluInc;
        alu_req.a  = DataW'(rd_entry.gen);
        alu_req.b  = '0;
      end
      default: alu_req = '0;
    endcase
  end

  // sequencer and table update
  always_comb begin
    state_d     = state_q;
    flag_a_d    = flag_a_q;
    flag_b_d    = flag_b_q;
    flag_c_d    = flag_c_q;
    free_head_d = free_head_q;
    used_d      = used_q;
    live_d      = live_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = in_q.handle_slot[SlotW-1:0];
    wr_entry    = '0;
    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          state_d = (in_data_i.action == ActClear) ? StUpd : StOwn;
        end
      end
      StOwn: begin
        flag_a_d = alu_rsp.flag;
        state_d  = is_create ? StUpd : StRange;
      end
      StRange: begin
        flag_b_d = alu_rsp.flag;
        state_d  = StGen;
      end
      StGen: begin
        flag_c_d = alu_rsp.flag;
        state_d  = StUpd;
      end
      StUpd: begin
        if (out_free) begin
          state_d     = StIdle;
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.status = StOk;
          case (in_q.action)
            ActCreate: begin
              if (have_free) begin
                ram_we         = 1'b1;
                ram_waddr      = free_head_q[SlotW-1:0];
                wr_entry.alive = 1'b1;
                wr_entry.gen   = rd_entry.gen;
                wr_entry.link  = IndexNone;
                free_head_d    = rd_entry.link;
                live_d         = live_q + CntW'(1);
                out_d.out_owner      = owner_q;
                out_d.out_slot       = 10'(free_head_q[SlotW-1:0]);
                out_d.out_generation = DataW'(rd_entry.gen);
              end else if (flag_a_q) begin
                ram_we         = 1'b1;
                ram_waddr      = used_q[SlotW-1:0];
                wr_entry.alive = 1'b1;
                wr_entry.gen   = GenFirst;
                wr_entry.link  = IndexNone;
                used_d         = used_q + CntW'(1);
                live_d         = live_q + CntW'(1);
                out_d.out_owner      = owner_q;
                out_d.out_slot       = 10'(used_q[SlotW-1:0]);
                out_d.out_generation = DataW'(GenFirst);
              end else begin
                out_d.status = StFull;
              end
            end
            ActDestroy: begin
              if (handle_ok) begin
                ram_we         = 1'b1;
                wr_entry.alive = 1'b0;
                wr_entry.gen   = alu_rsp.res[GenWidth-1:0];
                wr_entry.link  = free_head_q;
                free_head_d    = CntW'(in_q.handle_slot);
                if (live_q != '0) begin
                  live_d = live_q - CntW'(1);
                end
              end else begin
                out_d.status = StStale;
              end
            end
            ActCheck: begin
              out_d.status = handle_ok ? StOk : StStale;
            end
            ActClear: begin
              free_head_d = IndexNone;
              used_d      = '0;
              live_d      = '0;
            end
            default: out_d.status = StOk;
          endcase
          out_d.live_count = 11'(live_d);
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      free_head_q <= IndexNone;
      used_q      <= '0;
      live_q      <= '0;
      owner_q     <= DataW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      used_q      <= used_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) begin
        owner_q <= pwdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_data_i;
    end
    flag_a_q <= flag_a_d;
    flag_b_q <= flag_b_d;
    flag_c_q <= flag_c_d;
    out_q    <= out_d;
  end

endmodule

// File: rtl/gsa_ram.sv
module gsa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/gsa_alu.sv
module gsa_alu (
  input  gsa_pkg::alu_req_t req_i,
  output gsa_pkg::alu_rsp_t rsp_o
);
  import gsa_pkg::*;

  logic [GenWidth-1:0] gen_in;

  assign gen_in = req_i.a[GenWidth-1:0];

  // equality, less-than, or generation advance with wrap to one
  always_comb begin
    rsp_o = '0;
    case (req_i.op)
      AluEq: rsp_o.flag = (req_i.a == req_i.b);
      AluLt: rsp_o.flag = (req_i.a < req_i.b);
      AluInc: begin
        if (gen_in == GenMax) begin
          rsp_o.res = DataW'(GenFirst);
        end else begin
          rsp_o.res = DataW'(gen_in + GenFirst);
        end
      end
      default: rsp_o = '0;
    endcase
  end

endmodule

// File: rtl/gsa_checker.sv
module gsa_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input gsa_pkg::gsa_out_t out_data_o
);
  import gsa_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // one item at a time: busy right after an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while busy");

  // live count never exceeds the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.live_count <= 11'(SlotCount))
    else $error("live count above table size");

  // full only when every slot is live, and carries no handle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StFull |->
      out_data_o.live_count == 11'(SlotCount) && out_data_o.out_generation == '0)
    else $error("bad full result");

  // a handed-out generation is never zero and only comes with success
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_generation != '0 |-> out_data_o.status == StOk)
    else $error("handle with failing status");

endmodule

bind generational_slot_allocator gsa_checker u_gsa_checker (.*);
